/* sv/gmfig_pkg.sv */
// Shared types and constants for the geomipmap fan index generator.
// Used by the front, queue, back and top level modules; no dependencies.
package gmfig_pkg;

  // Field widths fixed by the interface
  localparam int unsigned COORD_W = 7;
  localparam int unsigned LOD_W   = 3;
  localparam int unsigned ROW_W   = 13;
  localparam int unsigned PSIZE_W = 7;
  localparam int unsigned VTX_W   = 24;
  localparam int unsigned SLOT_W  = 20;
  localparam int unsigned SC_W    = 8;   // 2^lod for lod up to 7
  localparam int unsigned EDGE_W  = 2;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 96;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIZE = 2'd1;

  // Rim walk order
  localparam logic [EDGE_W-1:0] EDGE_LEFT   = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_TOP    = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [EDGE_W-1:0] EDGE_BOTTOM = 2'd3;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_CW    = 2;

  // Live configuration
  typedef struct packed {
    logic [ROW_W-1:0]   row_width;
    logic [PSIZE_W-1:0] patch_size;
  } cfg_t;

  // One classified fan, ready for the rim walk
  typedef struct packed {
    logic [VTX_W-1:0] base;    // z*w + x, rim start
    logic [VTX_W-1:0] row_step; // w << lod
    logic [SC_W-1:0]  col_step; // 1 << lod
    logic             left;
    logic             right;
    logic             top;
    logic             bottom;
  } fan_job_t;

  // One triangle on the result side
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [VTX_W-1:0]  vertex_centre;
    logic [VTX_W-1:0]  vertex_second;
    logic [VTX_W-1:0]  vertex_third;
    logic              last_of_fan;
  } tri_t;

endpackage

/* sv/gmfig_front.sv */
// Front end: decodes one fan beat into a rim-walk job (base index, steps, coarse edges).
// Depends on gmfig_pkg.
module gmfig_front
  import gmfig_pkg::*;
#(
  parameter int unsigned MAX_LOD       = 5,
  parameter int unsigned MAX_ROW_WIDTH = 4097
) (
  input  cfg_t               cfg,
  input  logic [COORD_W-1:0] fan_x,
  input  logic [COORD_W-1:0] fan_z,
  input  logic [LOD_W-1:0]   core_lod,
  input  logic               left_coarser,
  input  logic               right_coarser,
  input  logic               top_coarser,
  input  logic               bottom_coarser,
  output fan_job_t           job
);

  logic [LOD_W-1:0]    lod;
  logic [ROW_W-1:0]    w;
  logic [SC_W-1:0]     sc;
  logic [SC_W:0]       fan;
  logic signed [10:0]  endp;
  logic [SLOT_W-1:0]   zw;

  // Saturate level and row width
  always_comb begin
    lod = (core_lod > LOD_W'(MAX_LOD)) ? LOD_W'(MAX_LOD) : core_lod;
    w   = (32'(cfg.row_width) > 32'(MAX_ROW_WIDTH)) ? ROW_W'(MAX_ROW_WIDTH)
                                                     : cfg.row_width;
  end

  // Fan geometry and patch edge tests
  always_comb begin
    sc   = SC_W'(1) << lod;
    fan  = {sc, 1'b0};
    endp = $signed({4'b0, cfg.patch_size}) - 11'sd1 - $signed({2'b0, fan});
  end

  assign zw = SLOT_W'(fan_z) * SLOT_W'(w);

  always_comb begin
    job.base     = VTX_W'(zw) + VTX_W'(fan_x);
    job.row_step = VTX_W'(w) << lod;
    job.col_step = sc;
    job.left     = left_coarser && (fan_x == '0);
    job.bottom   = bottom_coarser && (fan_z == '0);
    job.right    = right_coarser && ($signed({4'b0, fan_x}) == endp);
    job.top      = top_coarser && ($signed({4'b0, fan_z}) == endp);
  end

endmodule

/* sv/gmfig_queue.sv */
// Two-entry job queue decoupling the front end from the rim walker.
// Depends on gmfig_pkg.
module gmfig_queue
  import gmfig_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fan_job_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output fan_job_t head_data
);

  fan_job_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == Q_CW'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/gmfig_back.sv */
// Back end (uses gmfig_pkg): walks the queue head's fan rim into the output
// register, one triangle per unstalled cycle; owns the running slot counter.
module gmfig_back
  import gmfig_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  fan_job_t job,
  output logic     job_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output tri_t     out_tri
);

  logic [EDGE_W-1:0] edge_r, edge_nxt;
  logic              sub_r, sub_nxt;
  logic [VTX_W-1:0]  t_r;
  logic [SLOT_W-1:0] slot_r;
  logic              valid_r;
  tri_t              tri_r;

  logic              fire;
  logic              coarse;
  logic              end_of_edge;
  logic              last;
  logic [VTX_W-1:0]  step;
  logic [VTX_W-1:0]  ctr;
  logic [VTX_W-1:0]  va;
  logic [VTX_W-1:0]  vb;

  assign fire = job_valid && (!valid_r || out_ready);

  // Step size and coarse flag of the current rim edge
  always_comb begin
    unique case (edge_r)
      EDGE_LEFT: begin
        coarse = job.left;
        step   = job.left ? {job.row_step[VTX_W-2:0], 1'b0} : job.row_step;
      end
      EDGE_TOP: begin
        coarse = job.top;
        step   = job.top ? VTX_W'({job.col_step, 1'b0}) : VTX_W'(job.col_step);
      end
      EDGE_RIGHT: begin
        coarse = job.right;
        step   = job.right ? {job.row_step[VTX_W-2:0], 1'b0} : job.row_step;
      end
      default: begin
        coarse = job.bottom;
        step   = job.bottom ? VTX_W'({job.col_step, 1'b0}) : VTX_W'(job.col_step);
      end
    endcase
  end

  // Triangle vertices
  always_comb begin
    ctr = job.base + job.row_step + VTX_W'(job.col_step);
    va  = (edge_r == EDGE_LEFT && !sub_r) ? job.base : t_r;
    vb  = (edge_r == EDGE_LEFT || edge_r == EDGE_TOP) ? va + step : va - step;
    end_of_edge = coarse || sub_r;
    last        = (edge_r == EDGE_BOTTOM) && end_of_edge;
  end

  // Rim position sequencing
  always_comb begin
    edge_nxt = edge_r;
    sub_nxt  = sub_r;
    if (fire) begin
      if (end_of_edge) begin
        edge_nxt = edge_r + EDGE_W'(1);
        sub_nxt  = 1'b0;
      end else begin
        sub_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r  <= EDGE_LEFT;
      sub_r   <= 1'b0;
      slot_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      edge_r <= edge_nxt;
      sub_r  <= sub_nxt;
      if (fire) begin
        slot_r  <= slot_r + SLOT_W'(3);
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output register and rim vertex carry
  always_ff @(posedge clk) begin
    if (fire) begin
      t_r                 <= vb;
      tri_r.slot          <= slot_r;
      tri_r.vertex_centre <= ctr;
      tri_r.vertex_second <= va;
      tri_r.vertex_third  <= vb;
      tri_r.last_of_fan   <= last;
    end
  end

  assign job_pop   = fire && last;
  assign out_valid = valid_r;
  assign out_tri   = tri_r;

endmodule

/* sv/geomipmap_fan_index_generator_core.sv */
// Top level of the geomipmap fan index generator: configuration registers,
// front end, job queue and rim walker. Depends on gmfig_pkg and its submodules.
//
// Usage:
//   in_*  : one beat per triangle fan. tdata holds fan_x, fan_z, core_lod and
//           the four coarse-neighbor flags.
//   out_* : one beat per triangle: slot and three vertex indices in tdata,
//           tlast on the final triangle of a fan.
//   cfg_* : write enable, register index and data; index 0 is row_width,
//           index 1 patch_size, other indexes are dropped.
// The single rim walker gives one triangle per cycle while out_tready is high;
// a fan has 4 to 8 triangles (four plus one for each edge that is not coarse).
// Accepted fans wait in the job queue; triangles leave via the output register.
// A two-entry job queue lets fans be accepted while the walker is busy.
// Reset (rst_n low, synchronous) empties the queue and output register,
// restores row_width 257, patch_size 33 and the slot counter to zero.
// When out_tready is low the output register holds its triangle, the walker
// stops, and in_tready falls once the queue is full.
module geomipmap_fan_index_generator_core
  import gmfig_pkg::*;
#(
  parameter int unsigned MAX_LOD       = 5,
  parameter int unsigned MAX_ROW_WIDTH = 4097
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Fan beats: [6:0] fan_x, [13:7] fan_z, [16:14] core_lod, [17] left_coarser,
  // [18] right_coarser, [19] top_coarser, [20] bottom_coarser, [23:21] zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Triangle beats: [19:0] slot, [43:20] vertex_centre, [67:44] vertex_second,
  // [91:68] vertex_third, [95:92] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // Configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ROW_W-1:0]       cfg_wdata
);

  cfg_t     cfg_r;
  fan_job_t front_job;
  fan_job_t head_job;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  tri_t     tri_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_width  <= ROW_W'(257);
      cfg_r.patch_size <= PSIZE_W'(33);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH:  cfg_r.row_width  <= cfg_wdata;
        REG_PATCH_SIZE: cfg_r.patch_size <= cfg_wdata[PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  gmfig_front #(
    .MAX_LOD       (MAX_LOD),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_front (
    .cfg            (cfg_r),
    .fan_x          (in_tdata[6:0]),
    .fan_z          (in_tdata[13:7]),
    .core_lod       (in_tdata[16:14]),
    .left_coarser   (in_tdata[17]),
    .right_coarser  (in_tdata[18]),
    .top_coarser    (in_tdata[19]),
    .bottom_coarser (in_tdata[20]),
    .job            (front_job)
  );

  assign in_tready = !q_full;

  gmfig_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_data  (front_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_job)
  );

  gmfig_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (head_job),
    .job_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tri   (tri_out)
  );

  // Result packing
  assign out_tdata = {4'b0, tri_out.vertex_third, tri_out.vertex_second,
                      tri_out.vertex_centre, tri_out.slot};
  assign out_tlast = tri_out.last_of_fan;

endmodule

/* dv/tb_top.sv */
// Self-checking bench for the geomipmap fan index generator core.
// Needs gmfig_pkg and the core RTL; predicts every triangle and checks the out stream.
module tb_top
  import gmfig_pkg::*;
();

  localparam int unsigned LOD_CAP     = 5;
  localparam int unsigned ROW_CAP     = 4097;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_FANS  = 28;
  localparam int unsigned HOLD_CYCLES = 300;
  // Slowest correct run: the long receiver hold is the longest quiet stretch;
  // 77% gaps stay far shorter.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned PRINT_CAP   = 200;

  // Coarse flags as packed in tdata bits [20:17]
  localparam logic [3:0] C_NONE   = 4'b0000;
  localparam logic [3:0] C_LEFT   = 4'b0001;
  localparam logic [3:0] C_RIGHT  = 4'b0010;
  localparam logic [3:0] C_TOP    = 4'b0100;
  localparam logic [3:0] C_BOTTOM = 4'b1000;
  localparam logic [3:0] C_ALL    = 4'b1111;

  // Register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} gap_mode_e;

  // One fan beat, laid out as in tdata from the high bit down
  typedef struct packed {
    logic [3:0]         coarse;  // {bottom, top, right, left}
    logic [LOD_W-1:0]   lod;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] x;
  } fan_t;

  typedef struct packed {
    fan_t       fan;
    logic [3:0] golden_n;  // typed triangles to take from GOLDEN, 0 = predictor
  } dir_row_t;

  // Directed fans, run with the reset configuration (row 257, patch 33)
  localparam int unsigned DIR_N = 16;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{'{C_NONE,            3'd0, 7'd0,   7'd0},   4'd8},  // plain fan at the origin
    '{'{C_LEFT | C_BOTTOM, 3'd0, 7'd0,   7'd0},   4'd6},  // two coarse edges at the corner
    '{'{C_ALL,             3'd0, 7'd30,  7'd30},  4'd0},  // far corner: right and top count
    '{'{C_ALL,             3'd0, 7'd6,   7'd4},   4'd0},  // flags off every edge
    '{'{C_LEFT | C_TOP,    3'd0, 7'd30,  7'd0},   4'd0},
    '{'{C_ALL,             3'd4, 7'd0,   7'd0},   4'd0},  // fan spans patch: four triangles
    '{'{C_ALL,             3'd5, 7'd0,   7'd0},   4'd0},  // far edge below zero
    '{'{C_ALL,             3'd6, 7'd0,   7'd0},   4'd0},  // level saturates
    '{'{C_NONE,            3'd7, 7'd0,   7'd0},   4'd0},
    '{'{C_ALL,             3'd7, 7'd127, 7'd127}, 4'd0},  // every field at its top
    '{'{C_NONE,            3'd5, 7'd64,  7'd64},  4'd0},
    '{'{C_ALL,             3'd3, 7'd16,  7'd16},  4'd0},
    '{'{C_RIGHT | C_BOTTOM,3'd0, 7'd0,   7'd30},  4'd0},
    '{'{C_ALL,             3'd0, 7'd2,   7'd2},   4'd0},
    '{'{C_ALL,             3'd0, 7'd0,   7'd127}, 4'd0},
    '{'{C_ALL,             3'd2, 7'd127, 7'd0},   4'd0}
  };

  // Hand-worked triangles for the first two directed rows: {slot, centre, second, third, last}
  localparam tri_t GOLDEN [14] = '{
    '{20'd0,  24'd258, 24'd0,   24'd257, 1'b0},
    '{20'd3,  24'd258, 24'd257, 24'd514, 1'b0},
    '{20'd6,  24'd258, 24'd514, 24'd515, 1'b0},
    '{20'd9,  24'd258, 24'd515, 24'd516, 1'b0},
    '{20'd12, 24'd258, 24'd516, 24'd259, 1'b0},
    '{20'd15, 24'd258, 24'd259, 24'd2,   1'b0},
    '{20'd18, 24'd258, 24'd2,   24'd1,   1'b0},
    '{20'd21, 24'd258, 24'd1,   24'd0,   1'b1},
    '{20'd24, 24'd258, 24'd0,   24'd514, 1'b0},
    '{20'd27, 24'd258, 24'd514, 24'd515, 1'b0},
    '{20'd30, 24'd258, 24'd515, 24'd516, 1'b0},
    '{20'd33, 24'd258, 24'd516, 24'd259, 1'b0},
    '{20'd36, 24'd258, 24'd259, 24'd2,   1'b0},
    '{20'd39, 24'd258, 24'd2,   24'd0,   1'b1}
  };

  // Configuration for the first random phases: small, large, saturating, zero, even
  localparam int unsigned RW_PLAN [5] = '{3, 4097, 8191, 0, 4098};
  localparam int unsigned PS_PLAN [5] = '{3, 65, 127, 0, 2};
  localparam int unsigned PRESSURE_PHASE = 4;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [ROW_W-1:0]       cfg_wdata  = '0;

  // Shadow of the block's registers and slot counter
  logic [ROW_W-1:0]   row_model   = 13'd257;
  logic [PSIZE_W-1:0] psize_model = 7'd33;
  logic [SLOT_W-1:0]  slot_model  = '0;

  tri_t fan_tris[$];       // triangles of the fan just accepted
  tri_t expected_tris[$];  // triangles still owed by the block
  tri_t got_tri, want_tri;

  int unsigned snd_pct, rcv_pct;
  bit          hold_req;
  bit          hold_taken;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches, fans_sent, tris_checked, gold_ptr;

  geomipmap_fan_index_generator_core #(
    .MAX_LOD       (LOD_CAP),
    .MAX_ROW_WIDTH (ROW_CAP)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Triangles of one fan: walk the rim left, top, right, bottom
  function automatic void predict_fan(input fan_t f);
    logic [LOD_W-1:0] lvl;
    logic [VTX_W-1:0] w, sc, span, len, step, ctr, t1, t2;
    logic [3:0]       on_side;
    int               far_pos;
    fan_tris.delete();
    lvl  = (f.lod > LOD_CAP) ? LOD_W'(LOD_CAP) : f.lod;
    w    = (row_model > ROW_CAP) ? VTX_W'(ROW_CAP) : VTX_W'(row_model);
    sc   = VTX_W'(1) << lvl;
    span = sc << 1;
    far_pos = int'(psize_model) - 1 - int'(span);
    // a flag only counts on its own patch edge
    on_side[EDGE_LEFT]   = ((f.coarse & C_LEFT) != 0) && f.x == 0;
    on_side[EDGE_RIGHT]  = ((f.coarse & C_RIGHT) != 0) && int'(f.x) == far_pos;
    on_side[EDGE_TOP]    = ((f.coarse & C_TOP) != 0) && int'(f.z) == far_pos;
    on_side[EDGE_BOTTOM] = ((f.coarse & C_BOTTOM) != 0) && f.z == 0;
    ctr = (VTX_W'(f.z) + sc) * w + VTX_W'(f.x) + sc;
    t2  = VTX_W'(f.z) * w + VTX_W'(f.x);
    for (int s = 0; s < 4; s++) begin
      len = on_side[s] ? span : sc;
      case (EDGE_W'(s))
        EDGE_LEFT:  step = len * w;
        EDGE_TOP:   step = len;
        EDGE_RIGHT: step = -(len * w);
        default:    step = -len;
      endcase
      // coarse edge: one triangle skipping the middle vertex
      for (int k = 0; k < (on_side[s] ? 1 : 2); k++) begin
        t1 = t2;
        t2 = t2 + step;
        fan_tris.insert(fan_tris.size(), tri_t'{slot_model, ctr, t1, t2, 1'b0});
        slot_model = slot_model + SLOT_W'(3);
      end
    end
    fan_tris[fan_tris.size() - 1].last_of_fan = 1'b1;
  endfunction

  function automatic logic [COORD_W-1:0] draw_corner(input int unsigned span,
                                                     input int unsigned fan_len,
                                                     input int unsigned far_pos);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return COORD_W'(far_pos);
      default: return COORD_W'(fan_len * $urandom_range(0, span - 1));
    endcase
  endfunction

  // Mostly fans that fit the patch on the fan grid, the rest raw noise
  function automatic fan_t draw_fan();
    fan_t        f;
    int unsigned lvl, fan_len, span, far_pos;
    f.coarse = 4'($urandom);
    if (psize_model < 3 || $urandom_range(0, 99) < 20) begin
      f.x   = COORD_W'($urandom);
      f.z   = COORD_W'($urandom);
      f.lod = LOD_W'($urandom);
      return f;
    end
    lvl = $urandom_range(0, LOD_CAP);
    while ((2 << lvl) > psize_model - 1) lvl--;
    fan_len = 2 << lvl;
    span    = (psize_model - 1) / fan_len;
    far_pos = psize_model - 1 - fan_len;
    f.lod = LOD_W'(lvl);
    f.x   = draw_corner(span, fan_len, far_pos);
    f.z   = draw_corner(span, fan_len, far_pos);
    return f;
  endfunction

  function automatic void check_field(input string name, input logic [VTX_W-1:0] want_v,
                                      input logic [VTX_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endfunction

  function automatic void set_gaps(input gap_mode_e mode);
    snd_pct = (mode == GAPS_SENDER) ? 77 : (mode == GAPS_BOTH) ? 23 : 0;
    rcv_pct = (mode == GAPS_RECEIVER) ? 77 : (mode == GAPS_BOTH) ? 23 : 0;
  endfunction

  // Offer one fan beat, wait for the handshake, then queue its triangles
  task automatic push_fan(input fan_t f, input int unsigned golden_n);
    while ($urandom_range(0, 99) < snd_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, f};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    fans_sent++;
    predict_fan(f);
    if (golden_n != 0) begin
      repeat (golden_n) begin
        expected_tris.insert(expected_tris.size(), GOLDEN[gold_ptr]);
        gold_ptr++;
      end
    end else begin
      foreach (fan_tris[i]) expected_tris.insert(expected_tris.size(), fan_tris[i]);
    end
  endtask

  // Both registers plus one write to a spare index; upper patch bits carry junk
  task automatic load_config(input logic [ROW_W-1:0] rw, input logic [PSIZE_W-1:0] ps,
                             input logic [CFG_IDX_W-1:0] spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_WIDTH;
    cfg_wdata <= rw;
    @(posedge clk);
    cfg_index <= REG_PATCH_SIZE;
    cfg_wdata <= {6'($urandom), ps};
    @(posedge clk);
    cfg_index <= spare;
    cfg_wdata <= ROW_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    row_model   = rw;
    psize_model = ps;
  endtask

  task automatic wait_drained();
    while (expected_tris.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  // Triangle checker; sampled mid-cycle, the beat completes at the next edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_tri = {out_tdata[19:0], out_tdata[43:20], out_tdata[67:44], out_tdata[91:68],
                 out_tlast};
      tris_checked++;
      if (expected_tris.size() == 0) begin
        mismatches++;
        $error("unexpected triangle: slot %0d centre %0d", got_tri.slot,
               got_tri.vertex_centre);
      end else begin
        want_tri = expected_tris.pop_front();
        check_field("slot", VTX_W'(want_tri.slot), VTX_W'(got_tri.slot));
        check_field("vertex_centre", want_tri.vertex_centre, got_tri.vertex_centre);
        check_field("vertex_second", want_tri.vertex_second, got_tri.vertex_second);
        check_field("vertex_third", want_tri.vertex_third, got_tri.vertex_third);
        check_field("last_of_fan", VTX_W'(want_tri.last_of_fan),
                    VTX_W'(got_tri.last_of_fan));
      end
    end
  end

  // Watchdog on cycles with no beat on either stream
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d triangles outstanding",
                 quiet_cycles, expected_tris.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    set_gaps(GAPS_NONE);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed fans on the reset configuration
    foreach (DIR_ROWS[i]) push_fan(DIR_ROWS[i].fan, DIR_ROWS[i].golden_n);
    in_tvalid <= 1'b0;

    // Random phases, each with its own configuration and gap pattern
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p < 5)
        load_config(ROW_W'(RW_PLAN[p]), PSIZE_W'(PS_PLAN[p]), REG_SPARE_A);
      else if (p < PHASES - 1)
        load_config(ROW_W'($urandom_range(3, ROW_CAP)),
                    PSIZE_W'(2 * $urandom_range(1, 32) + 1), REG_SPARE_B);
      else
        load_config(ROW_W'($urandom_range(0, 8191)), PSIZE_W'($urandom_range(0, 127)),
                    REG_SPARE_A);
      set_gaps(gap_mode_e'(p % 4));
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      repeat (PHASE_FANS) push_fan(draw_fan(), 0);
      in_tvalid <= 1'b0;
    end
    wait_drained();

    $display("Run: %0d fans, %0d triangles checked, %0d configurations", fans_sent,
             tris_checked, PHASES + 1);
    $display("Covered: coarse edges, saturated level and row width, odd and even patch sizes, "
             , "sender gaps, receiver stalls and a long output hold");
    if (mismatches == 0 && expected_tris.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
